[rtl/core/lsps_pkg.sv]
// Shared codes and constants of the looping sample position stepper.
package lsps_pkg;

  localparam int unsigned JUMP_INT_BITS = 4;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_END_MODE   = 2'd0,
    REG_LOOP_START = 2'd1,
    REG_LOOP_END   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_LOAD    = 1'b1
  } cmd_e;

  typedef enum logic {
    END_WRAP     = 1'b0,
    END_SATURATE = 1'b1
  } end_mode_e;

endpackage

[rtl/core/lsps_step.sv]
// Next-position datapath: advance, wrap or clamp, load, and interpolation weights.
module lsps_step #(
  parameter int unsigned INT_BITS  = 24,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned POS_BITS = INT_BITS + FRAC_BITS,
  localparam int unsigned JUMP_W   = lsps_pkg::JUMP_INT_BITS + FRAC_BITS
) (
  input  lsps_pkg::cmd_e      cmd_i,
  input  logic [JUMP_W-1:0]   jump_i,
  input  logic [POS_BITS-1:0] new_pos_i,
  input  logic [POS_BITS-1:0] pos_i,
  input  lsps_pkg::end_mode_e end_mode_i,
  input  logic [POS_BITS-1:0] loop_start_i,
  input  logic [POS_BITS-1:0] loop_end_i,
  output logic [POS_BITS-1:0] pos_o,
  output logic [FRAC_BITS:0]  left_o,
  output logic [FRAC_BITS-1:0] right_o
);
  import lsps_pkg::*;

  logic [POS_BITS:0]   sum;
  logic [POS_BITS+1:0] wrapped;
  logic [POS_BITS-1:0] clamp;
  logic [POS_BITS-1:0] adv;
  logic                in_range;

  always_comb begin
    sum      = {1'b0, pos_i} + (POS_BITS + 1)'(jump_i);
    in_range = sum < {1'b0, loop_end_i};
    clamp    = (loop_end_i == '0) ? '0 : loop_end_i - POS_BITS'(1);
    wrapped  = {1'b0, sum} + (POS_BITS + 2)'(loop_start_i) - (POS_BITS + 2)'(loop_end_i);
    if (in_range) begin
      adv = sum[POS_BITS-1:0];
    end else if (end_mode_i == END_SATURATE) begin
      adv = clamp;
    end else if (wrapped[POS_BITS+1:POS_BITS] != 2'b00) begin
      adv = '1;
    end else begin
      adv = wrapped[POS_BITS-1:0];
    end
    unique case (cmd_i)
      CMD_LOAD:    pos_o = new_pos_i;
      CMD_ADVANCE: pos_o = adv;
      default:     pos_o = adv;
    endcase
    right_o = pos_o[FRAC_BITS-1:0];
    left_o  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, pos_o[FRAC_BITS-1:0]};
  end

endmodule

[rtl/core/looping_sample_position_stepper.sv]
// Top level of the looping sample position stepper: config, input and result registers.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: jump, new_position; tuser: cmd
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: sample_index, left/right, position
//  cfg       | in  | cfg_we_i (no ready)           | cfg_index_i, cfg_wdata_i
//
// One item per cycle unless m_axis stalls; items pass input, then result register.
// The position register is updated in the same cycle the item moves into the result
// register, so the next item always sees it: one adder, compare and wrap add per cycle.
// Reset clears the position to zero, loop start to zero and loop end to all ones.
// A stalled result holds in place; the input register still takes one more item.
module looping_sample_position_stepper #(
  parameter int unsigned INT_BITS  = 24,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned POS_BITS    = INT_BITS + FRAC_BITS,
  localparam int unsigned JUMP_W      = lsps_pkg::JUMP_INT_BITS + FRAC_BITS,
  localparam int unsigned IN_W        = JUMP_W + POS_BITS,
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W       = INT_BITS + 2 * FRAC_BITS + 1 + POS_BITS,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_TDATA_W-1:0]         s_axis_tdata,  // jump, new_position
  input  logic                          s_axis_tuser,  // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_TDATA_W-1:0]        m_axis_tdata,  // sample_index, left_weight,
                                                       // right_weight, position_out
  input  logic                          cfg_we_i,
  input  logic [lsps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_BITS-1:0]           cfg_wdata_i
);
  import lsps_pkg::*;

  logic                in_vld_q;
  cmd_e                in_cmd_q;
  logic [JUMP_W-1:0]   in_jump_q;
  logic [POS_BITS-1:0] in_pos_q;
  logic                out_vld_q;
  logic [OUT_W-1:0]    out_q;
  logic [POS_BITS-1:0] pos_q;
  end_mode_e           end_mode_q;
  logic [POS_BITS-1:0] loop_start_q;
  logic [POS_BITS-1:0] loop_end_q;

  logic                 advance;
  logic                 s_xfer;
  logic [POS_BITS-1:0]  pos_d;
  logic [FRAC_BITS:0]   left_d;
  logic [FRAC_BITS-1:0] right_d;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_mode_q   <= END_WRAP;
      loop_start_q <= '0;
      loop_end_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_END_MODE:   end_mode_q   <= end_mode_e'(cfg_wdata_i[0]);
        REG_LOOP_START: loop_start_q <= cfg_wdata_i;
        REG_LOOP_END:   loop_end_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          pos_q <= pos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_jump_q <= s_axis_tdata[JUMP_W-1:0];
      in_pos_q  <= s_axis_tdata[IN_W-1:JUMP_W];
    end
    if (advance && in_vld_q) begin
      out_q <= {pos_d, right_d, left_d, pos_d[POS_BITS-1:FRAC_BITS]};
    end
  end

  lsps_step #(
    .INT_BITS (INT_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_step (
    .cmd_i       (in_cmd_q),
    .jump_i      (in_jump_q),
    .new_pos_i   (in_pos_q),
    .pos_i       (pos_q),
    .end_mode_i  (end_mode_q),
    .loop_start_i(loop_start_q),
    .loop_end_i  (loop_end_q),
    .pos_o       (pos_d),
    .left_o      (left_d),
    .right_o     (right_d)
  );

endmodule

[rtl/core/lsps_checker.sv]
// Port-level checker for the looping sample position stepper, with its bind.
module lsps_checker #(
  parameter int unsigned INT_BITS  = 24,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned POS_BITS    = INT_BITS + FRAC_BITS,
  localparam int unsigned JUMP_W      = lsps_pkg::JUMP_INT_BITS + FRAC_BITS,
  localparam int unsigned IN_W        = JUMP_W + POS_BITS,
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W       = INT_BITS + 2 * FRAC_BITS + 1 + POS_BITS,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [IN_TDATA_W-1:0]          s_axis_tdata,  // jump, new_position
  input logic                           s_axis_tuser,  // cmd
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [OUT_TDATA_W-1:0]         m_axis_tdata,  // sample_index, left_weight,
                                                       // right_weight, position_out
  input logic                           cfg_we_i
);
  import lsps_pkg::*;

  localparam int unsigned LW_LO  = INT_BITS;
  localparam int unsigned RW_LO  = INT_BITS + FRAC_BITS + 1;
  localparam int unsigned POS_LO = INT_BITS + 2 * FRAC_BITS + 1;

  logic                s_xfer;
  logic [FRAC_BITS+1:0] weight_sum;

  assign s_xfer     = s_axis_tvalid && s_axis_tready;
  assign weight_sum = (FRAC_BITS + 2)'(m_axis_tdata[LW_LO +: FRAC_BITS+1])
                    + (FRAC_BITS + 2)'(m_axis_tdata[RW_LO +: FRAC_BITS]);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_weights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> weight_sum == ((FRAC_BITS + 2)'(1) << FRAC_BITS))
    else $error("left and right weights do not add to one");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while no result waits");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tuser == CMD_LOAD && !cfg_we_i ##1 (!m_axis_tvalid || m_axis_tready)
    |=> m_axis_tvalid
        && m_axis_tdata[POS_LO +: POS_BITS] == $past(s_axis_tdata[IN_W-1:JUMP_W], 2))
    else $error("loaded position not passed to the result");

endmodule

bind looping_sample_position_stepper lsps_checker #(
  .INT_BITS (INT_BITS),
  .FRAC_BITS(FRAC_BITS)
) u_lsps_checker (.*);

[tb/tb_looping_sample_position_stepper.sv]
// Testbench for the looping sample position stepper with an in-bench position predictor.
`timescale 1ns / 1ps

module tb_looping_sample_position_stepper;
  import lsps_pkg::*;

  localparam int unsigned POS_W      = 40;
  localparam int unsigned JUMP_W     = 20;
  localparam int unsigned IN_TDATA_W = 64;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [JUMP_W-1:0] JUMP_MAX = '1;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned IDLE_PCT = 31;

  typedef struct packed {
    logic [POS_W-1:0] position_out;
    logic [15:0]      right_weight;
    logic [16:0]      left_weight;
    logic [23:0]      sample_index;
  } pos_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // jump, new_position
  logic                   s_axis_tuser;   // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // sample_index, left_weight, right_weight, position_out
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [POS_W-1:0]       cfg_wdata_i;

  looping_sample_position_stepper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  end_mode_e        mode_q;
  logic [POS_W-1:0] lstart_q;
  logic [POS_W-1:0] lend_q;
  logic [POS_W-1:0] pos_q;

  pos_result_t pending_results[$];
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  bit          tx_idle_en;
  bit          rx_stall_en;
  int          rx_hold_cnt;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic pos_result_t step_position(cmd_e cmd, logic [JUMP_W-1:0] jump,
                                                logic [POS_W-1:0] new_pos);
    logic [POS_W+1:0] sum;
    pos_result_t r;
    if (cmd == CMD_LOAD) begin
      pos_q = new_pos;
    end else begin
      sum = {2'b00, pos_q} + {22'd0, jump};
      if (sum < {2'b00, lend_q}) begin
        pos_q = sum[POS_W-1:0];
      end else if (mode_q == END_SATURATE) begin
        pos_q = (lend_q == '0) ? '0 : lend_q - 1'b1;
      end else begin
        sum = sum - {2'b00, lend_q} + {2'b00, lstart_q};
        pos_q = (sum > {2'b00, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
      end
    end
    r.position_out = pos_q;
    r.right_weight = pos_q[15:0];
    r.left_weight  = 17'h10000 - {1'b0, pos_q[15:0]};
    r.sample_index = pos_q[POS_W-1:16];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] add_clip(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sub_clip(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic send_item(cmd_e cmd, logic [JUMP_W-1:0] jump, logic [POS_W-1:0] new_pos);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, new_pos, jump};
    s_axis_tuser  <= cmd;
    forever begin
      @(posedge clk_i);
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(step_position(cmd, jump, new_pos));
        break;
      end
    end
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [POS_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_END_MODE:   mode_q = end_mode_e'(val[0]);
      REG_LOOP_START: lstart_q = val;
      REG_LOOP_END:   lend_q = val;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_item(CMD_ADVANCE, '0, POS_MAX);
    send_item(CMD_ADVANCE, JUMP_MAX, '0);
    settle();
  endtask

  task automatic test_load_extremes();
    send_item(CMD_LOAD, JUMP_MAX, POS_MAX);
    send_item(CMD_ADVANCE, '0, '0);
    send_item(CMD_LOAD, '0, POS_MAX);
    send_item(CMD_ADVANCE, JUMP_MAX, POS_MAX);
    send_item(CMD_LOAD, 20'h5A5A5, '0);
    settle();
  endtask

  task automatic test_wrap();
    write_reg(REG_LOOP_START, 40'h00_0100_0000);
    write_reg(REG_LOOP_END, 40'h00_0200_0000);
    send_item(CMD_LOAD, '0, 40'h00_01FF_8000);
    send_item(CMD_ADVANCE, 20'h10000, 40'hA5_A5A5_A5A5);
    send_item(CMD_ADVANCE, 20'h08000, '0);
    send_item(CMD_ADVANCE, JUMP_MAX, '0);
    settle();
  endtask

  task automatic test_start_above_end();
    write_reg(REG_LOOP_START, POS_MAX);
    write_reg(REG_LOOP_END, 40'h00_0001_0000);
    send_item(CMD_LOAD, '0, 40'h00_0000_8000);
    send_item(CMD_ADVANCE, 20'h08000, '0);
    send_item(CMD_ADVANCE, 20'h00001, '0);
    settle();
  endtask

  task automatic test_saturate();
    write_reg(REG_END_MODE, POS_W'(END_SATURATE));
    write_reg(REG_LOOP_START, '0);
    write_reg(REG_LOOP_END, 40'h00_0300_0000);
    send_item(CMD_LOAD, '0, 40'h00_02FF_F000);
    send_item(CMD_ADVANCE, 20'h01000, '0);
    send_item(CMD_ADVANCE, JUMP_MAX, '0);
    settle();
    write_reg(REG_LOOP_END, '0);
    send_item(CMD_ADVANCE, '0, '0);
    send_item(CMD_LOAD, '0, 40'h12_3456_789A);
    send_item(CMD_ADVANCE, 20'h00005, '0);
    settle();
  endtask

  // Hold the result side off while the sender keeps offering.
  task automatic test_backpressure();
    write_reg(REG_END_MODE, POS_W'(END_WRAP));
    write_reg(REG_LOOP_START, 40'h00_0010_0000);
    write_reg(REG_LOOP_END, 40'h00_0040_0000);
    tx_idle_en = 1'b0;
    @(posedge clk_i);
    rx_hold_cnt = 120;
    repeat (30) send_item(CMD_ADVANCE, JUMP_W'($urandom_range(0, JUMP_MAX)), rand_pos());
    settle();
    tx_idle_en = 1'b1;
  endtask

  task automatic pick_config(int unsigned sel, bit sat);
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] e;
    case (sel % 6)
      0: begin
        s = rand_pos();
        e = add_clip(s, POS_W'($urandom_range(32'h10000, 32'h400_0000)));
      end
      1: begin
        s = '0;
        e = POS_MAX;
      end
      2: begin
        e = rand_pos();
        s = add_clip(e, POS_W'($urandom_range(1, 32'h100_0000)));
      end
      3: begin
        e = POS_W'($urandom_range(0, 32'h30000));
        s = $urandom_range(1) ? '0 : e >> 1;
      end
      4: begin
        e = POS_MAX;
        s = rand_pos();
      end
      default: begin
        e = POS_MAX - POS_W'($urandom_range(0, 32'h10_0000));
        s = sub_clip(e, 40'h00_0040_0000);
      end
    endcase
    write_reg(REG_END_MODE, POS_W'(sat ? END_SATURATE : END_WRAP));
    write_reg(REG_LOOP_START, s);
    write_reg(REG_LOOP_END, e);
  endtask

  task automatic test_random_phase(int unsigned n_items);
    logic [POS_W-1:0]  np;
    logic [JUMP_W-1:0] jp;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 2) settle();
      jp = JUMP_W'($urandom_range(0, JUMP_MAX));
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(3))
          0: np = rand_pos();
          1: np = sub_clip(lend_q, POS_W'($urandom_range(0, JUMP_MAX)));
          2: np = add_clip(lstart_q, POS_W'($urandom_range(0, JUMP_MAX)));
          default: np = $urandom_range(1) ? POS_MAX : '0;
        endcase
        send_item(CMD_LOAD, jp, np);
      end else begin
        case ($urandom_range(9))
          0: jp = '0;
          1: jp = JUMP_MAX;
          2, 3: jp = JUMP_W'($urandom_range(0, 32'h1FFFF));
          default: ;
        endcase
        send_item(CMD_ADVANCE, jp, rand_pos());
      end
    end
    settle();
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cnt = rx_hold_cnt - 1;
    end else begin
      m_axis_tready <= !(rx_stall_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    pos_result_t got;
    pos_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(pos_result_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: position_out %0h", got.position_out);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.sample_index !== want.sample_index) begin
          $error("sample_index: expected %0h, got %0h", want.sample_index, got.sample_index);
          mismatch_cnt++;
        end
        if (got.left_weight !== want.left_weight) begin
          $error("left_weight: expected %0h, got %0h", want.left_weight, got.left_weight);
          mismatch_cnt++;
        end
        if (got.right_weight !== want.right_weight) begin
          $error("right_weight: expected %0h, got %0h", want.right_weight, got.right_weight);
          mismatch_cnt++;
        end
        if (got.position_out !== want.position_out) begin
          $error("position_out: expected %0h, got %0h", want.position_out, got.position_out);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b1;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_END_MODE;
    cfg_wdata_i   = '0;
    mode_q        = END_WRAP;
    lstart_q      = '0;
    lend_q        = POS_MAX;
    pos_q         = '0;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    rx_hold_cnt   = 0;
    tx_idle_en    = 1'b1;
    rx_stall_en   = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_load_extremes();
    test_wrap();
    test_start_above_end();
    test_saturate();
    test_backpressure();
    for (int unsigned ph = 0; ph < 8; ph++) begin
      tx_idle_en  = (ph != 3);
      rx_stall_en = (ph != 3);
      pick_config(ph, ph[0]);
      test_random_phase(240);
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/lsps_pkg.sv
rtl/core/lsps_step.sv
rtl/core/looping_sample_position_stepper.sv
rtl/core/lsps_checker.sv
tb/tb_looping_sample_position_stepper.sv
